/* hdl/pcxrle_pkg.sv */
// Shared types and constants for the PCX run-length pixel stream decoder.
// No dependencies; imported by pcx_rle_image_decoder_core.
package pcxrle_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 13;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int PLN_W  = 2;
  localparam int CNT_W  = 6;
  // Byte offset within a whole encoded line (up to three planes of 8191 bytes)
  localparam int LPOS_W = 15;
  localparam int CIDX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [PLN_W-1:0]  plane_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [LPOS_W-1:0] lpos_t;
  typedef logic [CIDX_W-1:0] cfg_idx_t;

  // Count byte marker and repeat mask
  localparam byte_t RUN_MARK = 8'hC0;
  localparam byte_t RUN_MASK = 8'h3F;

  // Register indexes
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_LINE_BYTES   = 2'd2;
  localparam cfg_idx_t REG_THREE_PLANES = 2'd3;

  // Register reset values
  localparam cfg_t RST_IMAGE_WIDTH  = 13'd320;
  localparam cfg_t RST_IMAGE_HEIGHT = 13'd200;
  localparam cfg_t RST_LINE_BYTES   = 13'd320;

  // Plane codes
  localparam plane_t PLANE_RED   = 2'd0;
  localparam plane_t PLANE_GREEN = 2'd1;
  localparam plane_t PLANE_BLUE  = 2'd2;

endpackage

/* hdl/pcx_rle_image_decoder_core.sv */
// PCX run-length pixel stream decoder: top level with register file and run sequencer.
// Depends on pcxrle_pkg.
//
// The decoder accepts one compressed byte per request and is busy until that byte's
// pixels are in the output register. A count byte, or a data byte after a count of
// zero, is handled in S_IDLE alone. A literal, or a data byte after a count of n, is
// accepted in S_IDLE, takes an S_RUN step on the shared position-advance unit per
// repeat up to the line end, then releases the final pixel with last_of_run set in
// S_FLUSH. The output register lets a pixel wait for out_ready while the next run
// step proceeds, but a step stalls while that register is full and not being taken.
// Pixels at or past image_width are dropped, a run stops at the line end, and after
// image_height rows every byte is taken and ignored. Configuration writes are always
// taken and must be made while the decoder is idle.
module pcx_rle_image_decoder_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  pcxrle_pkg::cfg_idx_t      cfg_index,
  input  pcxrle_pkg::cfg_t          cfg_data,
  // Compressed byte channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcxrle_pkg::byte_t         code_byte,
  // Decoded pixel channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output pcxrle_pkg::byte_t         pixel_value,
  output pcxrle_pkg::col_t          column,
  output pcxrle_pkg::row_t          row,
  output pcxrle_pkg::plane_t        plane,
  output logic                      last_of_run
);
  import pcxrle_pkg::*;

  // Clamp limits, held to what the 13-bit registers can express
  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam cfg_t W_LIMIT = cfg_t'((MAX_WIDTH  > CFG_MAX) ? CFG_MAX : MAX_WIDTH);
  localparam cfg_t H_LIMIT = cfg_t'((MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t state;

  // Configuration registers
  cfg_t image_width;
  cfg_t image_height;
  cfg_t line_bytes;
  logic three_planes;

  // Decoder state
  logic   awaiting_data;
  count_t pending_count;
  lpos_t  line_position;
  lpos_t  plane_column;
  plane_t current_plane;
  cfg_t   current_row;
  logic   image_done;

  // Run in progress
  byte_t  data_byte;
  count_t count_left;

  // Pixel held back until it is known whether it ends the run
  logic   held_valid;
  byte_t  held_value;
  col_t   held_column;
  row_t   held_row;
  plane_t held_plane;

  // Effective limits
  cfg_t  eff_w;
  cfg_t  eff_h;
  cfg_t  lb;
  lpos_t line_len;

  always_comb begin
    eff_w = (image_width  > W_LIMIT) ? W_LIMIT : image_width;
    eff_h = (image_height > H_LIMIT) ? H_LIMIT : image_height;
    lb    = (line_bytes   > W_LIMIT) ? W_LIMIT : line_bytes;
    if (lb == '0) begin
      lb = cfg_t'(1);
    end
    line_len = three_planes ? (lpos_t'(lb) << 1) + lpos_t'(lb) : lpos_t'(lb);
  end

  // Shared position-advance unit: one run step
  logic   step_emit;
  lpos_t  pos_inc;
  lpos_t  col_inc;
  logic   line_end;
  logic   plane_end;
  cfg_t   row_inc;

  always_comb begin
    step_emit = plane_column < lpos_t'(eff_w);
    pos_inc   = line_position + lpos_t'(1);
    col_inc   = plane_column + lpos_t'(1);
    row_inc   = current_row + cfg_t'(1);
    line_end  = pos_inc >= line_len;
    plane_end = three_planes && (col_inc >= lpos_t'(lb)) && (current_plane < PLANE_BLUE);
  end

  // Handshake terms
  logic out_free;
  logic in_take;
  logic ignore_byte;
  logic is_count;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign in_take     = in_valid && in_ready;
  assign ignore_byte = image_done || (current_row >= eff_h);
  assign is_count    = ((code_byte & RUN_MARK) == RUN_MARK);

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      line_bytes    <= RST_LINE_BYTES;
      three_planes  <= 1'b0;
      awaiting_data <= 1'b0;
      pending_count <= '0;
      line_position <= '0;
      plane_column  <= '0;
      current_plane <= PLANE_RED;
      current_row   <= '0;
      image_done    <= 1'b0;
      count_left    <= '0;
      held_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Drop the output once taken; a load below overrides this
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_LINE_BYTES:   line_bytes   <= cfg_data;
          REG_THREE_PLANES: three_planes <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (ignore_byte) begin
              image_done <= 1'b1;
            end else if (!awaiting_data && is_count) begin
              pending_count <= count_t'(code_byte & RUN_MASK);
              awaiting_data <= 1'b1;
            end else begin
              data_byte     <= code_byte;
              pending_count <= '0;
              awaiting_data <= 1'b0;
              if (!awaiting_data) begin
                count_left <= count_t'(1);
                state      <= S_RUN;
              end else if (pending_count != '0) begin
                count_left <= pending_count;
                state      <= S_RUN;
              end
            end
          end
        end

        S_RUN: begin
          if (out_free) begin
            // Emit: release the earlier pixel, hold this one
            if (step_emit) begin
              if (held_valid) begin
                out_valid   <= 1'b1;
                pixel_value <= held_value;
                column      <= held_column;
                row         <= held_row;
                plane       <= held_plane;
                last_of_run <= 1'b0;
              end
              held_valid  <= 1'b1;
              held_value  <= data_byte;
              held_column <= plane_column[COL_W-1:0];
              held_row    <= current_row[ROW_W-1:0];
              held_plane  <= current_plane;
            end
            // Advance position
            if (line_end) begin
              line_position <= '0;
              plane_column  <= '0;
              current_plane <= PLANE_RED;
              current_row   <= row_inc;
              if (row_inc >= eff_h) begin
                image_done <= 1'b1;
              end
            end else begin
              line_position <= pos_inc;
              if (plane_end) begin
                current_plane <= current_plane + plane_t'(1);
                plane_column  <= '0;
              end else begin
                plane_column <= col_inc;
              end
            end
            count_left <= count_left - count_t'(1);
            if (line_end || count_left == count_t'(1)) begin
              state <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            pixel_value <= held_value;
            column      <= held_column;
            row         <= held_row;
            plane       <= held_plane;
            last_of_run <= 1'b1;
            held_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A held pixel never outlives its run
  a_held_in_run: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (state != S_IDLE))
    else $error("held pixel while idle");

  // A run step always has repeats left
  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (count_left != '0))
    else $error("run step with no repeats left");

  // The plane code stays within red, green, blue
  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    (current_plane == PLANE_RED) || (current_plane == PLANE_GREEN) ||
    (current_plane == PLANE_BLUE))
    else $error("plane out of range");

  // Once the image is done the decoder stays done
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    image_done |=> image_done)
    else $error("image done flag cleared");

  // A final pixel leaves only from the flush step
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_RUN) && out_valid && !$past(out_valid && !out_ready) |-> !last_of_run)
    else $error("final pixel released during run step");

endmodule

/* verif/pcx_rle_image_decoder_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pcx_rle_image_decoder_core: random and directed
// compressed byte streams, predicted pixels checked in order by a scoreboard class.
// Depends on pcxrle_pkg and pcx_rle_image_decoder_core.
module pcx_rle_image_decoder_core_tb;
  import pcxrle_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  // Longest busy stretch of one request is a 63-pixel run
  localparam int SETTLE_CYCLES = 80;
  localparam cfg_t HEIGHT_OPEN = 13'h1FFF;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    byte_t  value;
    col_t   col;
    row_t   row_idx;
    plane_t pln;
    logic   last;
  } pixel_t;

  // Decoder state copy and queue of pixels still to come out
  class pixel_scoreboard;
    cfg_t        width_reg;
    cfg_t        height_reg;
    cfg_t        pitch_reg;
    logic        planes_reg;
    bit          awaiting_data;
    bit          image_done;
    count_t      run_count;
    int unsigned line_pos;
    int unsigned plane_col;
    int unsigned cur_plane;
    int unsigned cur_row;
    pixel_t      expected_pixels[$];
    int          errors;

    function new();
      width_reg     = RST_IMAGE_WIDTH;
      height_reg    = RST_IMAGE_HEIGHT;
      pitch_reg     = RST_LINE_BYTES;
      planes_reg    = 1'b0;
      awaiting_data = 1'b0;
      image_done    = 1'b0;
      run_count     = '0;
      line_pos      = 0;
      plane_col     = 0;
      cur_plane     = 0;
      cur_row       = 0;
      errors        = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_t data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data;
        REG_IMAGE_HEIGHT: height_reg = data;
        REG_LINE_BYTES:   pitch_reg  = data;
        REG_THREE_PLANES: planes_reg = data[0];
        default: ;
      endcase
    endfunction

    // Decode one accepted request and queue the pixels it yields
    function void note_request(byte_t code);
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned pitch;
      int unsigned line_len;
      int unsigned reps;
      pixel_t      held;
      bit          have_held;
      w_eff = (width_reg > MAX_W) ? MAX_W : width_reg;
      h_eff = (height_reg > MAX_H) ? MAX_H : height_reg;
      pitch = (pitch_reg > MAX_W) ? MAX_W : pitch_reg;
      if (pitch == 0) pitch = 1;
      line_len  = planes_reg ? pitch * 3 : pitch;
      have_held = 1'b0;

      // Drop everything once the last row is through
      if (image_done || cur_row >= h_eff) begin
        image_done = 1'b1;
        return;
      end

      // A count byte only arms the next byte
      if (!awaiting_data) begin
        if ((code & RUN_MARK) == RUN_MARK) begin
          run_count     = count_t'(code & RUN_MASK);
          awaiting_data = 1'b1;
          return;
        end
        reps = 1;
      end else begin
        reps          = run_count;
        run_count     = '0;
        awaiting_data = 1'b0;
      end

      // Walk the run; drop padding columns, cut the run at the line end
      while (reps > 0) begin
        reps--;
        if (plane_col < w_eff) begin
          if (have_held) expected_pixels.push_back(held);
          held.value   = code;
          held.col     = col_t'(plane_col);
          held.row_idx = row_t'(cur_row);
          held.pln     = plane_t'(cur_plane);
          held.last    = 1'b0;
          have_held    = 1'b1;
        end
        line_pos++;
        plane_col++;
        if (line_pos >= line_len) begin
          line_pos  = 0;
          plane_col = 0;
          cur_plane = 0;
          cur_row++;
          if (cur_row >= h_eff) image_done = 1'b1;
          break;
        end
        if (planes_reg && plane_col >= pitch && cur_plane < 2) begin
          cur_plane++;
          plane_col = 0;
        end
      end

      // Mark the final pixel of this request
      if (have_held) begin
        held.last = 1'b1;
        expected_pixels.push_back(held);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual value %0d col %0d row %0d plane %0d",
                 $time, got.value, got.col, got.row_idx, got.pln);
        return;
      end
      want = expected_pixels.pop_front();
      check_field("pixel_value", want.value, got.value);
      check_field("column", want.col, got.col);
      check_field("row", want.row_idx, got.row_idx);
      check_field("plane", want.pln, got.pln);
      check_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = REG_IMAGE_WIDTH;
  cfg_t     cfg_data  = '0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  byte_t    code_byte = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  byte_t    pixel_value;
  col_t     column;
  row_t     row;
  plane_t   plane;
  logic     last_of_run;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  pixel_scoreboard sb = new();

  always #5 clk = ~clk;

  pcx_rle_image_decoder_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_value(pixel_value),
    .column     (column),
    .row        (row),
    .plane      (plane),
    .last_of_run(last_of_run)
  );

  // Take pixels and randomly stall the output
  always @(posedge clk) begin : take_pixels
    pixel_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.value   = pixel_value;
        got.col     = column;
        got.row_idx = row;
        got.pln     = plane;
        got.last    = last_of_run;
        sb.check_pixel(got);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 47 : (mode == IDLE_BOTH) ? 18 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 47 : (mode == IDLE_BOTH) ? 18 : 0;
  endtask

  // Hold one compressed byte until the request is taken
  task automatic send_code(byte_t code);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    code_byte <= code;
    do @(posedge clk); while (!in_ready);
    sb.note_request(code);
  endtask

  task automatic send_run(count_t reps, byte_t data);
    send_code(RUN_MARK | byte_t'(reps));
    send_code(data);
  endtask

  // Drop valid, wait for every pending pixel, then let the core go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(cfg_idx_t idx, cfg_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_format(cfg_t w, cfg_t h, cfg_t lb, logic tp);
    program_reg(REG_IMAGE_WIDTH, w);
    program_reg(REG_IMAGE_HEIGHT, h);
    program_reg(REG_LINE_BYTES, lb);
    program_reg(REG_THREE_PLANES, cfg_t'(tp));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed runs and literals, with some raw noise bytes
  task automatic random_codes(int n_items);
    int     sent;
    int     pick;
    int     sel;
    count_t reps;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        sel = $urandom_range(99);
        if (sel < 10) reps = '0;
        else if (sel < 20) reps = 6'd63;
        else if (sel < 65) reps = count_t'($urandom_range(6, 1));
        else reps = count_t'($urandom_range(62, 7));
        send_run(reps, byte_t'($urandom_range(255)));
        sent += 2;
      end else if (pick < 92) begin
        send_code(byte_t'($urandom_range(8'hBF)));
        sent++;
      end else begin
        send_code(byte_t'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic run_phase(idle_mode_t mode, cfg_t w, cfg_t h, cfg_t lb, logic tp,
                           int n_items);
    set_idling(mode);
    set_format(w, h, lb, tp);
    random_codes(n_items);
    settle();
  endtask

  initial begin : stimulus
    int start_row;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: literal extremes, zero count, data with count bits, longest run
    set_idling(IDLE_NONE);
    send_code(8'h00);
    send_code(8'hBF);
    send_code(8'h40);
    send_code(8'h7F);
    send_run(6'd0, 8'h55);
    send_run(6'd1, 8'hFF);
    send_run(6'd63, 8'hC3);
    settle();

    // Short planar line: shrink mid-line, padding, plane steps, cut-off run
    set_format(13'd3, HEIGHT_OPEN, 13'd5, 1'b1);
    send_run(6'd7, 8'h11);
    send_code(8'h80);
    send_run(6'd63, 8'h22);
    send_run(6'd2, 8'hC9);
    send_code(8'h01);
    send_run(6'd0, 8'hAA);
    settle();

    // Full-width line of longest runs, out to the last column
    set_idling(IDLE_RECEIVER);
    set_format(13'h1FFF, HEIGHT_OPEN, 13'd4096, 1'b0);
    start_row = sb.cur_row;
    while (sb.cur_row == start_row && !sb.image_done)
      send_run(6'd63, byte_t'($urandom_range(255)));
    settle();

    run_phase(IDLE_BOTH, 13'd1, HEIGHT_OPEN, 13'd1, 1'b0, 40);
    run_phase(IDLE_SENDER, 13'd0, HEIGHT_OPEN, 13'd0, 1'b1, 15);
    run_phase(IDLE_NONE, 13'd5, 13'd4096, 13'd7, 1'b1, 50);
    run_phase(IDLE_RECEIVER, 13'd4096, 13'd4096, 13'h1FFF, 1'b1, 40);
    run_phase(IDLE_BOTH, 13'd20, HEIGHT_OPEN, 13'd16, 1'b0, 40);
    run_phase(IDLE_SENDER, 13'd9, HEIGHT_OPEN, 13'd12, 1'b1, 40);
    // End the image two rows on; later bytes are dropped
    run_phase(IDLE_BOTH, 13'd8, cfg_t'(sb.cur_row + 2), 13'd8, 1'b0, 40);
    run_phase(IDLE_NONE, 13'd8, 13'd0, 13'd8, 1'b0, 6);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/pcxrle_pkg.sv
hdl/pcx_rle_image_decoder_core.sv
verif/pcx_rle_image_decoder_core_tb.sv
